/* hdl/bmsi_pkg.sv */
// ----------------------------------------------------------------------------
// Bank mapper package
// Shared types, codes and constants of the bank mapper with scanline IRQ.
// ----------------------------------------------------------------------------
`default_nettype none

package bmsi_pkg;

  // Stream payload widths.
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;

  // Configuration port.
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // Item kinds carried on the input tuser.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TICK  = 2'd1,
    OP_PRG   = 2'd2,
    OP_CHR   = 2'd3
  } op_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_WIRING    = 2'd0,
    REG_PIRATE    = 2'd1,
    REG_CHR_SHIFT = 2'd2,
    REG_PRG_HIGH  = 2'd3
  } reg_idx_t;

  // Address line wirings.
  typedef enum logic [1:0] {
    WIRE_SHIFTED = 2'd0,
    WIRE_SWAPPED = 2'd1,
    WIRE_ORED    = 2'd2,
    WIRE_PLAIN   = 2'd3
  } wiring_t;

  // Register groups, selected by the top address nibble.
  localparam logic [3:0] NIB_PRG0      = 4'h8;
  localparam logic [3:0] NIB_MISC      = 4'h9;
  localparam logic [3:0] NIB_PRG1      = 4'hA;
  localparam logic [3:0] NIB_CHR_FIRST = 4'hB;
  localparam logic [3:0] NIB_CHR_LAST  = 4'hE;
  localparam logic [3:0] NIB_IRQ       = 4'hF;

  // Registers inside the IRQ group, by low address bits.
  localparam logic [1:0] IRQ_LATCH_LO = 2'd0;
  localparam logic [1:0] IRQ_LATCH_HI = 2'd1;
  localparam logic [1:0] IRQ_CONTROL  = 2'd2;
  localparam logic [1:0] IRQ_ACK      = 2'd3;

  localparam logic [7:0]  MIRROR_IGNORE   = 8'hFF;
  localparam logic [10:0] PRESCALE_PERIOD = 11'd341;
  localparam logic [5:0]  FIXED_SECOND    = 6'd30;
  localparam logic [5:0]  FIXED_LAST      = 6'd31;

  typedef struct packed {
    wiring_t wiring;
    logic    pirate;
    logic    chr_shift;
    logic    prg_high;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic wrap;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic tick_run;
    logic acc_ge;
  } ctl_sts_t;

endpackage

`default_nettype wire

/* hdl/bank_mapper_with_scanline_irq_core.sv */
// ----------------------------------------------------------------------------
// Bank mapper with scanline IRQ, top level
// Register writes, IRQ prescaler ticks and bank translate queries.
// ----------------------------------------------------------------------------
// A write or translate item passes the execute and done states, and its result
// is loaded into the output register once that register is free. A tick with the
// IRQ enabled adds wrap states: one prescaler wrap per cycle (at most three) plus
// a final pass that stores the remainder. Only one item is in flight; the next
// transfer is taken in the cycle after the result enters the output register.
// Reset (rst, synchronous) clears configuration, all bank and IRQ state and
// the output register's valid flag.
`default_nettype none

module bank_mapper_with_scanline_irq_core (
  input  wire  logic                          clk,
  input  wire  logic                          rst,
  // s_tdata: address[15:0], data[23:16], cycles[31:24]
  input  wire  logic                          s_tvalid,
  output logic                                s_tready,
  input  wire  logic [bmsi_pkg::IN_DATA_W-1:0] s_tdata,
  // s_tuser: opcode[1:0]
  input  wire  logic [bmsi_pkg::IN_USER_W-1:0] s_tuser,
  // m_tdata: bank[8:0], mirroring[10:9], irq_pending[11], zero[15:12]
  output logic                                m_tvalid,
  input  wire  logic                          m_tready,
  output logic [bmsi_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  wire  logic                          psel,
  input  wire  logic                          penable,
  input  wire  logic                          pwrite,
  input  wire  logic [bmsi_pkg::APB_AW-1:0]   paddr,
  input  wire  logic [bmsi_pkg::APB_DW-1:0]   pwdata,
  output logic [bmsi_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);
  import bmsi_pkg::*;

  cfg_t     cfg;
  ctl_cmd_t cmd;
  ctl_sts_t sts;
  reg_idx_t reg_sel;
  logic     cfg_we;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{wiring: WIRE_SHIFTED, default: 1'b0};
    end else if (cfg_we) begin
      case (reg_sel)
        REG_WIRING:    cfg.wiring    <= wiring_t'(pwdata[1:0]);
        REG_PIRATE:    cfg.pirate    <= pwdata[0];
        REG_CHR_SHIFT: cfg.chr_shift <= pwdata[0];
        REG_PRG_HIGH:  cfg.prg_high  <= pwdata[0];
        default:       cfg           <= cfg;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIRING:    prdata = {30'd0, cfg.wiring};
      REG_PIRATE:    prdata = {31'd0, cfg.pirate};
      REG_CHR_SHIFT: prdata = {31'd0, cfg.chr_shift};
      REG_PRG_HIGH:  prdata = {31'd0, cfg.prg_high};
      default:       prdata = '0;
    endcase
  end

  bmsi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bmsi_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .cmd     (cmd),
    .sts     (sts),
    .m_tdata (m_tdata)
  );

  // Only one item is worked on at a time.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in flight");

  // A new result never overwrites one that has not been taken.
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("pending result overwritten");

  // The output becomes valid only through a result load.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.load_out))
    else $error("output valid without a result load");

  // Wrap steps only run for an enabled tick, never alongside an item load.
  assert property (@(posedge clk) disable iff (rst)
    cmd.wrap |-> (!cmd.load_in && !cmd.exec && !cmd.load_out))
    else $error("wrap step overlaps another command");

endmodule

`default_nettype wire

/* hdl/bmsi_ctrl.sv */
// ----------------------------------------------------------------------------
// Bank mapper controller
// Sequences one item through execute, prescaler wrap steps and output load.
// ----------------------------------------------------------------------------
`default_nettype none

module bmsi_ctrl (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic s_tvalid,
  output logic                     s_tready,
  output logic                     m_tvalid,
  input  wire                logic m_tready,
  input  wire  bmsi_pkg::ctl_sts_t sts,
  output bmsi_pkg::ctl_cmd_t       cmd
);
  import bmsi_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_WRAP = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.tick_run ? ST_WRAP : ST_DONE;
      end
      ST_WRAP: begin
        // One wrap of the prescaler per cycle; the last pass stores the remainder.
        cmd.wrap = 1'b1;
        if (!sts.acc_ge) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/bmsi_dpath.sv */
// ----------------------------------------------------------------------------
// Bank mapper datapath
// Item registers, bank and IRQ state, address decode and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmsi_dpath (
  input  wire                logic                         clk,
  input  wire                logic                         rst,
  input  wire  bmsi_pkg::cfg_t                             cfg,
  input  wire                logic [bmsi_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire                logic [bmsi_pkg::IN_USER_W-1:0] s_tuser,
  input  wire  bmsi_pkg::ctl_cmd_t                         cmd,
  output bmsi_pkg::ctl_sts_t                               sts,
  output logic [bmsi_pkg::OUT_DATA_W-1:0]                  m_tdata
);
  import bmsi_pkg::*;

  // Item registers.
  op_t         op_r;
  logic [15:0] addr_r;
  logic [7:0]  data_r;
  logic [7:0]  cyc_r;

  // Mapper state.
  logic [5:0]  prg_banks [2];
  logic [7:0]  chr_banks_low [8];
  logic        chr_banks_high [8];
  logic        prg_swap;
  logic [1:0]  mirror_mode;
  logic [7:0]  irq_latch;
  logic [8:0]  irq_counter;
  logic [10:0] prescaler;
  logic        irq_enable;
  logic        irq_enable_after_ack;
  logic        irq_line;

  logic [10:0] acc;
  logic [8:0]  bank_r;

  // Decode and arithmetic.
  logic [3:0]  hi_nib;
  logic [1:0]  lo;
  logic [1:0]  low_or;
  logic        is_chr;
  logic [3:0]  chr_off;
  logic [2:0]  chr_slot;
  logic [10:0] tick_sum;
  logic [8:0]  cnt_inc;
  logic [5:0]  prg_sel;
  logic [8:0]  prg_bank;
  logic [2:0]  q_slot;
  logic [8:0]  chr_raw;
  logic [8:0]  chr_bank;
  logic [5:0]  pair_bank;

  assign hi_nib = addr_r[15:12];
  assign low_or = addr_r[1:0] | addr_r[3:2];

  always_comb begin
    case (cfg.wiring)
      WIRE_SHIFTED: lo = addr_r[2:1];
      WIRE_SWAPPED: lo = {low_or[0], low_or[1]};
      WIRE_ORED:    lo = low_or | addr_r[5:4] | addr_r[7:6];
      default:      lo = addr_r[1:0];
    endcase
  end

  // Character registers pair up as two per nibble; lo[1] picks the odd one.
  assign is_chr   = (hi_nib >= NIB_CHR_FIRST) && (hi_nib <= NIB_CHR_LAST);
  assign chr_off  = hi_nib - NIB_CHR_FIRST;
  assign chr_slot = {chr_off[1:0], lo[1]};

  assign tick_sum = prescaler + {2'b00, cyc_r, 1'b0} + {3'b000, cyc_r};
  assign cnt_inc  = irq_counter + 9'd1;
  assign pair_bank = {data_r[4:0], 1'b0};

  always_comb begin
    case (addr_r[14:13])
      2'd0:    prg_sel = prg_swap ? FIXED_SECOND : prg_banks[0];
      2'd1:    prg_sel = prg_banks[1];
      2'd2:    prg_sel = prg_swap ? prg_banks[0] : FIXED_SECOND;
      default: prg_sel = FIXED_LAST;
    endcase
    if (addr_r[15]) begin
      prg_bank = {3'b000, prg_sel | {cfg.prg_high, 5'b00000}};
    end else begin
      prg_bank = '0;
    end
  end

  assign q_slot   = addr_r[12:10];
  assign chr_raw  = {chr_banks_high[q_slot], chr_banks_low[q_slot]};
  assign chr_bank = cfg.chr_shift ? {1'b0, chr_raw[8:1]} : chr_raw;

  assign sts.tick_run = (op_r == OP_TICK) && irq_enable;
  assign sts.acc_ge   = acc >= PRESCALE_PERIOD;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= op_t'(s_tuser);
      addr_r <= s_tdata[15:0];
      data_r <= s_tdata[23:16];
      cyc_r  <= s_tdata[31:24];
    end
    if (cmd.exec && (op_r == OP_TICK)) begin
      acc <= tick_sum;
    end else if (cmd.wrap && sts.acc_ge) begin
      acc <= acc - PRESCALE_PERIOD;
    end
    if (cmd.exec) begin
      case (op_r)
        OP_PRG:  bank_r <= prg_bank;
        OP_CHR:  bank_r <= chr_bank;
        default: bank_r <= '0;
      endcase
    end
    if (cmd.load_out) begin
      m_tdata <= {4'b0000, irq_line, mirror_mode, bank_r};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        prg_banks[i] <= '0;
      end
      for (int i = 0; i < 8; i++) begin
        chr_banks_low[i]  <= '0;
        chr_banks_high[i] <= 1'b0;
      end
      prg_swap             <= 1'b0;
      mirror_mode          <= '0;
      irq_latch            <= '0;
      irq_counter          <= '0;
      prescaler            <= '0;
      irq_enable           <= 1'b0;
      irq_enable_after_ack <= 1'b0;
      irq_line             <= 1'b0;
    end else begin
      if (cmd.exec && (op_r == OP_WRITE)) begin
        if (is_chr) begin
          if (lo[0]) begin
            chr_banks_low[chr_slot][7:4] <= data_r[3:0];
            chr_banks_high[chr_slot]     <= data_r[4];
          end else begin
            chr_banks_low[chr_slot][3:0] <= data_r[3:0];
          end
        end else begin
          case (hi_nib)
            NIB_PRG0: begin
              if (!cfg.pirate) begin
                prg_banks[0] <= {1'b0, data_r[4:0]};
              end
            end
            NIB_PRG1: begin
              if (!cfg.pirate) begin
                prg_banks[1] <= {1'b0, data_r[4:0]};
              end else begin
                prg_banks[0] <= pair_bank;
                prg_banks[1] <= pair_bank | 6'd1;
              end
            end
            NIB_MISC: begin
              if (lo[1]) begin
                prg_swap <= data_r[1];
              end else if (data_r != MIRROR_IGNORE) begin
                mirror_mode <= data_r[1:0];
              end
            end
            NIB_IRQ: begin
              irq_line <= 1'b0;
              case (lo)
                IRQ_LATCH_LO: irq_latch[3:0] <= data_r[3:0];
                IRQ_LATCH_HI: irq_latch[7:4] <= data_r[3:0];
                IRQ_CONTROL: begin
                  prescaler            <= '0;
                  irq_counter          <= {1'b0, irq_latch};
                  irq_enable           <= data_r[1];
                  irq_enable_after_ack <= data_r[0];
                end
                IRQ_ACK:      irq_enable <= irq_enable_after_ack;
                default:      irq_enable <= irq_enable;
              endcase
            end
            default: begin
              irq_line <= irq_line;
            end
          endcase
        end
      end
      if (cmd.wrap) begin
        if (sts.acc_ge) begin
          if (cnt_inc[8]) begin
            irq_line    <= 1'b1;
            irq_counter <= {1'b0, irq_latch};
          end else begin
            irq_counter <= cnt_inc;
          end
        end else begin
          prescaler <= acc;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* verif/tb_bank_mapper_with_scanline_irq_core.sv */
// ----------------------------------------------------------------------------
// Bank mapper with scanline IRQ, testbench
// Streams register writes, prescaler ticks and bank lookups into the mapper under
// several address wirings and mode settings. A behavioral copy of the mapper predicts
// each result not fixed by a directed row; all are compared field by field in order.
// ----------------------------------------------------------------------------

module tb_bank_mapper_with_scanline_irq_core;

  timeunit 1ns;
  timeprecision 1ps;

  import bmsi_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 75;

  typedef struct packed {
    logic [8:0] bank;
    logic [1:0] mirroring;
    logic       irq_pending;
  } mapper_result_t;

  typedef struct {
    op_t            op;
    logic [15:0]    addr;
    logic [7:0]     data;
    logic [7:0]     cyc;
    bit             known;
    mapper_result_t want;
  } lookup_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_AW-1:0]     paddr = '0;
  logic [APB_DW-1:0]     pwdata = '0;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  bank_mapper_with_scanline_irq_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Mapper state as the predictor sees it; everything starts at its reset value.
  cfg_t        model_cfg = '0;
  logic [5:0]  prg_bank [2] = '{default: '0};
  logic [7:0]  chr_lo [8] = '{default: '0};
  logic        chr_hi [8] = '{default: '0};
  logic        prg_swap_q = 1'b0;
  logic [1:0]  mirror_q = '0;
  logic [7:0]  irq_latch_q = '0;
  logic [8:0]  irq_count_q = '0;
  logic [10:0] prescale_q = '0;
  logic        irq_en_q = 1'b0;
  logic        irq_en_ack_q = 1'b0;
  logic        irq_line_q = 1'b0;

  mapper_result_t bank_results_due [$];
  int mismatch_count = 0;
  int results_checked = 0;
  int irq_results = 0;
  int op_count [4] = '{default: 0};
  int quiet_cycles = 0;
  logic no_idle = 1'b0;
  logic hold_req = 1'b0;

  function automatic mapper_result_t mapper_step(op_t op, logic [15:0] addr,
                                                 logic [7:0] data, logic [7:0] cyc);
    mapper_result_t r;
    logic [15:0] w;
    logic [1:0]  t;
    logic [3:0]  grp;
    logic [3:0]  slot_off;
    logic [1:0]  sel;
    logic [2:0]  slot;
    logic [5:0]  b6;
    logic [8:0]  b9;
    int          acc;
    r = '0;
    case (op)
      OP_WRITE: begin
        case (model_cfg.wiring)
          WIRE_SHIFTED: w = {addr[15:12], 10'd0, addr[2:1]};
          WIRE_SWAPPED: begin
            t = addr[1:0] | addr[3:2];
            w = {addr[15:12], 10'd0, t[0], t[1]};
          end
          WIRE_ORED: w = addr | {14'd0, addr[3:2] | addr[5:4] | addr[7:6]};
          default: w = addr;
        endcase
        grp = w[15:12];
        sel = w[1:0];
        if (grp >= NIB_CHR_FIRST && grp <= NIB_CHR_LAST) begin
          // Two character slots per address group, picked by the second low line.
          slot_off = grp - NIB_CHR_FIRST;
          slot = {slot_off[1:0], sel[1]};
          if (sel[0]) begin
            chr_lo[slot][7:4] = data[3:0];
            chr_hi[slot] = data[4];
          end else begin
            chr_lo[slot][3:0] = data[3:0];
          end
        end else begin
          case (grp)
            NIB_PRG0: begin
              if (!model_cfg.pirate) prg_bank[0] = {1'b0, data[4:0]};
            end
            NIB_PRG1: begin
              if (!model_cfg.pirate) begin
                prg_bank[1] = {1'b0, data[4:0]};
              end else begin
                prg_bank[0] = {data[4:0], 1'b0};
                prg_bank[1] = {data[4:0], 1'b1};
              end
            end
            NIB_MISC: begin
              if (!sel[1]) begin
                if (data != MIRROR_IGNORE) mirror_q = data[1:0];
              end else begin
                prg_swap_q = data[1];
              end
            end
            NIB_IRQ: begin
              irq_line_q = 1'b0;
              case (sel)
                IRQ_LATCH_LO: irq_latch_q[3:0] = data[3:0];
                IRQ_LATCH_HI: irq_latch_q[7:4] = data[3:0];
                IRQ_CONTROL: begin
                  prescale_q = '0;
                  irq_count_q = {1'b0, irq_latch_q};
                  irq_en_q = data[1];
                  irq_en_ack_q = data[0];
                end
                default: irq_en_q = irq_en_ack_q;
              endcase
            end
            default: ;
          endcase
        end
      end
      OP_TICK: begin
        if (irq_en_q) begin
          acc = int'(prescale_q) + 3 * int'(cyc);
          while (acc >= int'(PRESCALE_PERIOD)) begin
            acc = acc - int'(PRESCALE_PERIOD);
            irq_count_q = irq_count_q + 9'd1;
            if (irq_count_q[8]) begin
              irq_line_q = 1'b1;
              irq_count_q = {1'b0, irq_latch_q};
            end
          end
          prescale_q = acc[10:0];
        end
      end
      OP_PRG: begin
        if (addr[15]) begin
          case (addr[14:13])
            2'd0: b6 = prg_swap_q ? FIXED_SECOND : prg_bank[0];
            2'd1: b6 = prg_bank[1];
            2'd2: b6 = prg_swap_q ? prg_bank[0] : FIXED_SECOND;
            default: b6 = FIXED_LAST;
          endcase
          if (model_cfg.prg_high) b6[5] = 1'b1;
          r.bank = {3'd0, b6};
        end
      end
      default: begin
        b9 = {chr_hi[addr[12:10]], chr_lo[addr[12:10]]};
        if (model_cfg.chr_shift) b9 = b9 >> 1;
        r.bank = b9;
      end
    endcase
    r.mirroring = mirror_q;
    r.irq_pending = irq_line_q;
    return r;
  endfunction

  // Builds an address that lands on a given register under the current wiring.
  // Bits 11..8 are ignored by every wiring and are filled at random.
  function automatic logic [15:0] reg_address(logic [3:0] nib, logic [1:0] sel);
    logic [31:0] rnd;
    logic [15:0] a;
    rnd = $urandom;
    a = {nib, rnd[11:8], rnd[7:0]};
    case (model_cfg.wiring)
      WIRE_SHIFTED: a[2:1] = sel;
      WIRE_SWAPPED: a[3:0] = {2'b00, sel[0], sel[1]};
      WIRE_ORED:    a[7:0] = {6'd0, sel};
      default:      a[1:0] = sel;
    endcase
    return a;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatch_count < 30)
      $display("ERROR result %0d: %s got 0x%0h, want 0x%0h", results_checked, what, got, want);
    mismatch_count++;
  endtask

  task automatic program_register(reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) report_mismatch("register readback", prdata, value);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_WIRING:    model_cfg.wiring = wiring_t'(value[1:0]);
      REG_PIRATE:    model_cfg.pirate = value[0];
      REG_CHR_SHIFT: model_cfg.chr_shift = value[0];
      default:       model_cfg.prg_high = value[0];
    endcase
    @(posedge clk);
  endtask

  // Offers one item and records its expected result once the transfer happens.
  task automatic offer_item(op_t op, logic [15:0] addr, logic [7:0] data, logic [7:0] cyc,
                            bit known, mapper_result_t fixed_want);
    mapper_result_t want;
    while (!no_idle && $urandom_range(0, 99) < 35) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {cyc, data, addr};
    s_tuser <= op;
    do @(posedge clk); while (!s_tready);
    want = mapper_step(op, addr, data, cyc);
    if (known) want = fixed_want;
    bank_results_due.push_back(want);
    op_count[op]++;
    if (want.irq_pending) irq_results++;
  endtask

  // Directed rows run with the reset configuration (shifted wiring, all modes off).
  lookup_row_t directed_rows [25] = '{
    // Fixed banks and empty character banks straight after reset.
    '{OP_PRG,   16'hE000, 8'h00, 8'h00, 1'b1, '{9'd31, 2'd0, 1'b0}},
    '{OP_PRG,   16'hC000, 8'hFF, 8'hFF, 1'b1, '{9'd30, 2'd0, 1'b0}},
    // Program lookups below the program window return zero.
    '{OP_PRG,   16'h7FFF, 8'h00, 8'h00, 1'b1, '{9'd0,  2'd0, 1'b0}},
    '{OP_PRG,   16'h0000, 8'h00, 8'h00, 1'b1, '{9'd0,  2'd0, 1'b0}},
    // Character lookups above the pattern area wrap onto the eight slots.
    '{OP_CHR,   16'hFFFF, 8'h00, 8'h00, 1'b1, '{9'd0,  2'd0, 1'b0}},
    '{OP_WRITE, 16'h8000, 8'hFF, 8'h00, 1'b0, '0},
    '{OP_WRITE, 16'hA000, 8'h15, 8'hFF, 1'b0, '0},
    '{OP_PRG,   16'h8000, 8'h00, 8'h00, 1'b0, '0},
    '{OP_PRG,   16'hA000, 8'h00, 8'h00, 1'b0, '0},
    '{OP_WRITE, 16'h9000, 8'h03, 8'h00, 1'b0, '0},
    // A mirroring write of all ones leaves the mode alone.
    '{OP_WRITE, 16'h9000, 8'hFF, 8'h00, 1'b0, '0},
    '{OP_WRITE, 16'h9004, 8'h02, 8'h00, 1'b0, '0},
    '{OP_PRG,   16'h8000, 8'h00, 8'h00, 1'b0, '0},
    '{OP_PRG,   16'hC000, 8'h00, 8'h00, 1'b0, '0},
    '{OP_WRITE, 16'hB000, 8'h0F, 8'h00, 1'b0, '0},
    '{OP_WRITE, 16'hB002, 8'hFF, 8'h00, 1'b0, '0},
    '{OP_CHR,   16'h0000, 8'h00, 8'h00, 1'b0, '0},
    // Writes outside the register window are dropped.
    '{OP_WRITE, 16'h7FFF, 8'hAA, 8'h00, 1'b0, '0},
    '{OP_WRITE, 16'hF000, 8'h0F, 8'h00, 1'b0, '0},
    '{OP_WRITE, 16'hF002, 8'h0F, 8'h00, 1'b0, '0},
    '{OP_WRITE, 16'hF004, 8'h02, 8'h00, 1'b0, '0},
    '{OP_TICK,  16'hFFFF, 8'hFF, 8'hFF, 1'b0, '0},
    '{OP_TICK,  16'h0000, 8'h00, 8'h00, 1'b0, '0},
    // Acknowledge clears the line, then a disabled counter ignores ticks.
    '{OP_WRITE, 16'hF006, 8'h00, 8'h00, 1'b0, '0},
    '{OP_TICK,  16'h1234, 8'h55, 8'hFF, 1'b0, '0}
  };

  initial begin : stimulus
    logic [31:0] rnd;
    logic [7:0]  wdata;
    int          pick;
    int          phase;
    int          n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    program_register(REG_WIRING, 32'(WIRE_SHIFTED));
    program_register(REG_PIRATE, 32'd0);
    program_register(REG_CHR_SHIFT, 32'd0);
    program_register(REG_PRG_HIGH, 32'd0);
    foreach (directed_rows[i])
      offer_item(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].data,
                 directed_rows[i].cyc, directed_rows[i].known, directed_rows[i].want);

    for (phase = 0; phase < PHASES; phase++) begin
      // The configuration only changes once every outstanding result is back.
      s_tvalid <= 1'b0;
      while (bank_results_due.size() != 0) @(posedge clk);
      program_register(REG_WIRING, 32'(phase % 4));
      program_register(REG_PIRATE, (phase < 2) ? 32'(phase) : 32'($urandom_range(0, 1)));
      program_register(REG_CHR_SHIFT, (phase < 2) ? 32'(phase) : 32'($urandom_range(0, 1)));
      program_register(REG_PRG_HIGH, (phase < 2) ? 32'(phase) : 32'($urandom_range(0, 1)));
      no_idle <= (phase == 3);
      if (phase == 2) hold_req <= 1'b1;

      // Arm the counter with a high latch so that overflows come often.
      rnd = $urandom;
      offer_item(OP_WRITE, reg_address(NIB_IRQ, IRQ_LATCH_LO), rnd[7:0], rnd[15:8], 1'b0, '0);
      offer_item(OP_WRITE, reg_address(NIB_IRQ, IRQ_LATCH_HI), {rnd[23:20], 4'hF},
                 rnd[31:24], 1'b0, '0);
      offer_item(OP_WRITE, reg_address(NIB_IRQ, IRQ_CONTROL), {rnd[15:10], 1'b1, rnd[9]},
                 rnd[7:0], 1'b0, '0);

      for (n = 3; n < PHASE_ITEMS; n++) begin
        rnd = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          wdata = (rnd[12:10] == 3'd0) ? MIRROR_IGNORE : rnd[31:24];
          offer_item(OP_WRITE, reg_address({1'b1, rnd[2:0]}, rnd[4:3]), wdata, rnd[23:16],
                     1'b0, '0);
        end else if (pick < 35) begin
          offer_item(OP_WRITE, rnd[15:0], rnd[23:16], rnd[31:24], 1'b0, '0);
        end else if (pick < 60) begin
          offer_item(OP_TICK, rnd[15:0], rnd[23:16], rnd[31:24], 1'b0, '0);
        end else if (pick < 80) begin
          offer_item(OP_PRG, rnd[15:0], rnd[23:16], rnd[31:24], 1'b0, '0);
        end else begin
          offer_item(OP_CHR, rnd[15:0], rnd[23:16], rnd[31:24], 1'b0, '0);
        end
      end
    end

    s_tvalid <= 1'b0;
    while (bank_results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d writes, %0d ticks, %0d program and %0d character lookups",
             op_count[OP_WRITE], op_count[OP_TICK], op_count[OP_PRG], op_count[OP_CHR]);
    $display("over %0d mapper settings; %0d results carried a raised interrupt.",
             PHASES + 1, irq_results);
    if (mismatch_count == 0) begin
      $display("PASS bank_mapper_with_scanline_irq_core");
    end else begin
      $display("FAIL bank_mapper_with_scanline_irq_core");
    end
    $finish;
  end

  // Result side: random backpressure, plus one long hold-off on request.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = 80;
        hold_req <= 1'b0;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 35);
      end
    end
  end

  always @(posedge clk) begin : result_check
    mapper_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (bank_results_due.size() == 0) begin
        report_mismatch("result with nothing outstanding", 32'(m_tdata), 0);
      end else begin
        want = bank_results_due.pop_front();
        if (m_tdata[8:0] !== want.bank)
          report_mismatch("bank", 32'(m_tdata[8:0]), 32'(want.bank));
        if (m_tdata[10:9] !== want.mirroring)
          report_mismatch("mirroring", 32'(m_tdata[10:9]), 32'(want.mirroring));
        if (m_tdata[11] !== want.irq_pending)
          report_mismatch("irq_pending", 32'(m_tdata[11]), 32'(want.irq_pending));
        if (m_tdata[15:12] !== 4'd0)
          report_mismatch("padding", 32'(m_tdata[15:12]), 0);
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("FAIL bank_mapper_with_scanline_irq_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

/* filelist.f */
hdl/bmsi_pkg.sv
hdl/bmsi_ctrl.sv
hdl/bmsi_dpath.sv
hdl/bank_mapper_with_scanline_irq_core.sv
verif/tb_bank_mapper_with_scanline_irq_core.sv
